### rtl/core/psh_pkg.sv
// Package for the polynomial string hash core: modulus constants, the
// term record passed from the term pipeline to the accumulator, and
// modular reduction helpers. No dependencies.
package psh_pkg;

	localparam int unsigned HASH_W = 30;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned PROD_W = 38;
	localparam int unsigned FOLD_W = 35;

	localparam logic [HASH_W-1:0] PRIME = 30'd1000000009;
	localparam logic [HASH_W-1:0] POWER_ONE = 30'd1;
	localparam logic [8:0] CHAR_OFFSET = 9'd96;
	// 2^30 mod PRIME, used to fold the bits above bit 29
	localparam logic [HASH_W-1:0] C30 = 30'd73741815;
	// 2^64 mod PRIME, the residue of a wrapped 64-bit sum
	localparam logic [HASH_W-1:0] C64 = 30'((65'd1 << 64) % 65'd1000000009);

	// One reduced term on its way to the accumulator
	typedef struct packed {
		logic              valid;
		logic              last;
		logic              neg;
		logic              big;
		logic [HASH_W-1:0] r;
	} term_t;

	// hi * 2^30 + lo folded to hi * C30 + lo, for hi below 32
	function automatic logic [31:0] fold5(input logic [4:0] hi, input logic [HASH_W-1:0] lo);
		fold5 = 32'(hi) * 32'(C30) + 32'(lo);
	endfunction

	// Reduce a value below 4 * PRIME
	function automatic logic [HASH_W-1:0] red4(input logic [31:0] y);
		logic [31:0] p1;
		logic [31:0] p2;
		logic [31:0] p3;
		p1 = 32'(PRIME);
		p2 = p1 + p1;
		p3 = p2 + p1;
		if (y >= p3) begin
			red4 = 30'(y - p3);
		end else if (y >= p2) begin
			red4 = 30'(y - p2);
		end else if (y >= p1) begin
			red4 = 30'(y - p1);
		end else begin
			red4 = 30'(y);
		end
	endfunction

endpackage

### rtl/core/polynomial_string_hash_core.sv
// Polynomial string hash core: base-31 rolling hash modulo 1000000009,
// one character per item, the hash out on the last character.
// The result passes the term stages s1 to s4 and the result register before it is valid.
// Throughput: one item per cycle while no result is stalled at the output.
// Reset (arst_n, asynchronous): pipe empty, hash 0, power 1.
module polynomial_string_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_code
	input  logic        s_tlast,  // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [29:0] string_hash, [31:30] zero
);
	import psh_pkg::*;

	logic              en;
	logic [HASH_W-1:0] power;
	logic [HASH_W-1:0] out_hash;
	term_t             term;

	// Move the whole pipe unless a result is stalled at the output
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	psh_power u_power (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (s_tvalid && en),
		.last   (s_tlast),
		.power  (power)
	);

	psh_term u_term (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.char_code (s_tdata),
		.last_char (s_tlast),
		.power     (power),
		.term      (term)
	);

	psh_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.term      (term),
		.out_take  (m_tready),
		.out_valid (m_tvalid),
		.out_hash  (out_hash)
	);

	assign m_tdata = {2'b00, out_hash};

endmodule

### rtl/core/psh_power.sv
// Running power of the base for the polynomial string hash core.
// Depends on psh_pkg for the modulus constants and reduction helpers.
module psh_power (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 last,
	output logic [psh_pkg::HASH_W-1:0] power
);
	import psh_pkg::*;

	logic [HASH_W-1:0] power_q;
	logic [FOLD_W-1:0] times31;
	logic [HASH_W-1:0] power_next;

	// Multiply by 31 as 32p - p, fold the top bits and reduce
	always_comb begin
		times31 = (FOLD_W'(power_q) << 5) - FOLD_W'(power_q);
		power_next = red4(fold5(times31[FOLD_W-1:HASH_W], times31[HASH_W-1:0]));
	end

	// Advance on every accepted item, restart at one after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q <= POWER_ONE;
		end else if (accept) begin
			power_q <= last ? POWER_ONE : power_next;
		end
	end

	assign power = power_q;

endmodule

### rtl/core/psh_term.sv
// Term pipeline of the polynomial string hash core: input register,
// offset and multiply, two folds and a final reduction modulo the prime.
// Depends on psh_pkg for constants, the term record and reduction helpers.
module psh_term (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [psh_pkg::CHAR_W-1:0] char_code,
	input  logic                       last_char,
	input  logic [psh_pkg::HASH_W-1:0] power,
	output psh_pkg::term_t             term
);
	import psh_pkg::*;

	logic              v_s1, v_s2, v_s3, v_s4;
	logic              last_s1, last_s2, last_s3, last_s4;
	logic              neg_s2, neg_s3, neg_s4;
	logic              big_s3, big_s4;
	logic [CHAR_W-1:0] char_s1;
	logic [HASH_W-1:0] power_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [FOLD_W-1:0] fold_s3;
	logic [HASH_W-1:0] r_s4;

	logic [8:0]        diff;
	logic              neg;
	logic [CHAR_W-1:0] mag;
	logic [FOLD_W-1:0] fold1;

	// Signed byte minus the offset, split into sign and magnitude
	always_comb begin
		diff = {char_s1[CHAR_W-1], char_s1} - CHAR_OFFSET;
		neg = diff[8];
		mag = neg ? CHAR_W'(-diff) : diff[CHAR_W-1:0];
	end

	// First fold of the product: bits above 29 times 2^30 mod prime
	always_comb begin
		fold1 = FOLD_W'(prod_s2[PROD_W-1:HASH_W]) * FOLD_W'(C30)
			+ FOLD_W'(prod_s2[HASH_W-1:0]);
	end

	// Stage valid bits, advance together when the pipe moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			char_s1  <= char_code;
			last_s1  <= last_char;
			power_s1 <= power;

			prod_s2  <= PROD_W'(mag) * PROD_W'(power_s1);
			neg_s2   <= neg;
			last_s2  <= last_s1;

			fold_s3  <= fold1;
			big_s3   <= prod_s2 >= PROD_W'(PRIME);
			neg_s3   <= neg_s2;
			last_s3  <= last_s2;

			r_s4     <= red4(fold5(fold_s3[FOLD_W-1:HASH_W], fold_s3[HASH_W-1:0]));
			big_s4   <= big_s3;
			neg_s4   <= neg_s3;
			last_s4  <= last_s3;
		end
	end

	assign term.valid = v_s4;
	assign term.last  = last_s4;
	assign term.neg   = neg_s4;
	assign term.big   = big_s4;
	assign term.r     = r_s4;

endmodule

### rtl/core/psh_accum.sv
// Running hash and result register of the polynomial string hash core.
// Applies the 64-bit wrap of negative terms. Depends on psh_pkg.
module psh_accum (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  psh_pkg::term_t             term,
	input  logic                       out_take,
	output logic                       out_valid,
	output logic [psh_pkg::HASH_W-1:0] out_hash
);
	import psh_pkg::*;

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] out_q;
	logic              out_valid_q;
	logic [HASH_W-1:0] hash_next;
	logic [HASH_W:0]   sum;
	logic [HASH_W+2:0] wrap;

	// Next hash: plain add, plain subtract, or residue of the wrapped sum
	always_comb begin
		sum  = (HASH_W+1)'(hash_q) + (HASH_W+1)'(term.r);
		wrap = (HASH_W+3)'(hash_q) + (HASH_W+3)'(C64) - (HASH_W+3)'(term.r);
		if (!term.neg) begin
			hash_next = (sum >= (HASH_W+1)'(PRIME)) ? HASH_W'(sum - (HASH_W+1)'(PRIME))
				: sum[HASH_W-1:0];
		end else if (!term.big && term.r <= hash_q) begin
			hash_next = hash_q - term.r;
		end else if (wrap[HASH_W+2]) begin
			hash_next = HASH_W'(wrap + (HASH_W+3)'(PRIME));
		end else if (wrap >= (HASH_W+3)'(PRIME)) begin
			hash_next = HASH_W'(wrap - (HASH_W+3)'(PRIME));
		end else begin
			hash_next = wrap[HASH_W-1:0];
		end
	end

	// Hold the running hash, clear it after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (en && term.valid) begin
			hash_q <= term.last ? '0 : hash_next;
		end
	end

	// Result valid: set on a finished string, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && term.valid && term.last) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result data
	always_ff @(posedge clk) begin
		if (en && term.valid && term.last) begin
			out_q <= hash_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_hash  = out_q;

endmodule

### rtl/core/psh_checker.sv
// Port checker for the polynomial string hash core, with its bind.
// Sees only the top-level ports. Depends on psh_pkg for the prime.
module psh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);
	import psh_pkg::*;

	// Hash is fully reduced
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[HASH_W-1:0] < PRIME)
		else $error("hash not reduced");

	// Pad bits stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:30] == 2'b00)
		else $error("pad bits set");

	// Input stalls only behind a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output backpressure");

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind polynomial_string_hash_core psh_checker u_psh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/testbench.sv
// Testbench for polynomial_string_hash_core: streams strings one character per item
// and checks each finished hash against a behavioral base-31 hash kept in step with it.
// Depends only on the core RTL and its package.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] HASH_MOD = 64'd1000000009;
	localparam logic [63:0] HASH_BASE = 64'd31;
	localparam int MAX_REPORTS = 10;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;  // [7:0] char_code
	logic        s_tlast;  // last_char
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;  // [29:0] string_hash, [31:30] zero

	// Behavioral hash state and the hashes still owed by the core
	logic [29:0] acc_hash;
	logic [29:0] acc_power;
	logic [29:0] hash_expected[$];
	int          hash_errors;
	bit          idle_on;
	int          rx_stall_left;

	polynomial_string_hash_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold off a hung run
	initial begin
		#10_000_000;
		$display("testbench: errors");
		$finish;
	end

	// Fold one accepted character into the running hash; queue the hash on the last one
	task automatic hash_absorb(input logic [7:0] code, input logic last);
		longint      term_s;
		logic [63:0] term_u;
		logic [63:0] sum;
		term_s = longint'($signed(code)) - 64'sd96;
		term_u = term_s;
		// product and sum wrap at 64 bits before the reduction
		sum = {34'b0, acc_hash} + term_u * {34'b0, acc_power};
		acc_hash = 30'(sum % HASH_MOD);
		acc_power = 30'(({34'b0, acc_power} * HASH_BASE) % HASH_MOD);
		if (last) begin
			hash_expected.push_back(acc_hash);
			acc_hash = '0;
			acc_power = 30'd1;
		end
	endtask

	// Mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Send one character item and wait for it to be taken
	task automatic send_char(input logic [7:0] code, input logic last);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= code;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		hash_absorb(code, last);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and hold until every owed hash has come out
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (hash_expected.size() != 0) @(posedge clk);
	endtask

	// Check each hash taken from the core; stall the output at random
	always @(posedge clk) begin
		logic [29:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (hash_expected.size() == 0) begin
				hash_errors++;
				if (hash_errors <= MAX_REPORTS)
					$display("unexpected hash %0d", m_tdata);
			end else begin
				want = hash_expected.pop_front();
				if (m_tdata !== {2'b00, want}) begin
					hash_errors++;
					if (hash_errors <= MAX_REPORTS)
						$display("hash mismatch: expected %0d, got %0d (tdata %h)",
							want, m_tdata[29:0], m_tdata);
				end
			end
		end
		if (!idle_on) begin
			m_tready <= 1'b1;
		end else if (rx_stall_left > 0) begin
			rx_stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < 70) begin
			m_tready <= 1'b1;
		end else begin
			rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
			m_tready <= 1'b0;
		end
	end

	// One-character strings at the byte extremes and around the offset
	task automatic test_single_chars();
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);
		send_char(8'h7F, 1'b1);
		send_char(8'h80, 1'b1);
		send_char(8'h60, 1'b1);
		send_char(8'h61, 1'b1);
		send_char(8'h7A, 1'b1);
	endtask

	// Short words, intermediate characters give no hash; negative terms mid-string
	task automatic test_short_words();
		send_char(8'h61, 1'b0);
		send_char(8'h62, 1'b0);
		send_char(8'h63, 1'b1);
		send_char(8'h00, 1'b0);
		send_char(8'h80, 1'b1);
	endtask

	// Long enough for the power to wrap past the prime
	task automatic test_power_wrap();
		repeat (9) send_char(8'h7F, 1'b0);
		send_char(8'h80, 1'b1);
	endtask

	// Random strings: mostly letters, some raw bytes, some extremes
	task automatic test_random_strings(input int n_items);
		int          sent;
		int          len;
		int          style;
		int          r;
		logic [7:0]  code;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				len = $urandom_range(1, 8);
			end else if (r < 95) begin
				len = $urandom_range(9, 24);
			end else begin
				len = $urandom_range(25, 48);
			end
			style = $urandom_range(0, 99);
			for (int i = 0; i < len; i++) begin
				if (style < 60) begin
					code = 8'($urandom_range(97, 122));
				end else if (style < 85) begin
					code = 8'($urandom);
				end else begin
					case ($urandom_range(0, 4))
						0: code = 8'h00;
						1: code = 8'h7F;
						2: code = 8'h80;
						3: code = 8'hFF;
						default: code = 8'h60;
					endcase
				end
				send_char(code, i == len - 1);
			end
			sent += len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		acc_hash = '0;
		acc_power = 30'd1;
		hash_errors = 0;
		idle_on = 1'b1;
		rx_stall_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_chars();
		test_short_words();
		test_power_wrap();
		wait_drain();
		test_random_strings(1500);
		// back-to-back stretch with no idling on either side
		idle_on = 1'b0;
		test_random_strings(400);
		idle_on = 1'b1;
		wait_drain();
		repeat (10) @(posedge clk);

		hash_errors += hash_expected.size();
		if (hash_errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/psh_pkg.sv
rtl/core/psh_power.sv
rtl/core/psh_term.sv
rtl/core/psh_accum.sv
rtl/core/polynomial_string_hash_core.sv
rtl/core/psh_checker.sv
tb/testbench.sv
